/* design/stable_priority_queue_defines.svh */
// ---------------------------------------------------------------------------
// stable_priority_queue_defines.svh
// Assertion helpers shared by the priority queue RTL.
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_DEFINES_SVH
`define STABLE_PRIORITY_QUEUE_DEFINES_SVH

// Clocked check, off while reset is high.
`define SPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Same check, but also evaluated during reset.
`define SPQ_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/spq_pkg.sv */
// ---------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the sorted priority queue.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH_DEF          = 16;
  localparam int PRIORITY_WIDTH_DEF = 8;
  localparam int HANDLE_WIDTH_DEF   = 16;
  localparam int STATUS_W           = 2;

  localparam logic OP_ENQ = 1'b0;
  localparam logic OP_DEQ = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } spq_status_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic enq;  // accepted enqueue, queue not full
    logic deq;  // accepted dequeue, queue not empty
  } spq_ctl_t;

endpackage

/* design/spq_cell.sv */
// ---------------------------------------------------------------------------
// spq_cell
// One slot of the sorted queue: holds an entry, shifts toward the tail on
// insert ahead of it, toward the head on dequeue.
// ---------------------------------------------------------------------------
module spq_cell #(
  parameter int IDX            = 0,
  parameter int DEPTH          = spq_pkg::DEPTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
  parameter int HANDLE_WIDTH   = spq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                        clk,
  input  spq_pkg::spq_ctl_t           ctl,
  input  logic [$clog2(DEPTH+1)-1:0]  count,
  input  logic [HANDLE_WIDTH-1:0]     new_handle,
  input  logic [PRIORITY_WIDTH-1:0]   new_prio,
  input  logic                        lt_prev,
  input  logic [HANDLE_WIDTH-1:0]     prev_handle,
  input  logic [PRIORITY_WIDTH-1:0]   prev_prio,
  input  logic [HANDLE_WIDTH-1:0]     next_handle,
  input  logic [PRIORITY_WIDTH-1:0]   next_prio,
  output logic                        lt,
  output logic [HANDLE_WIDTH-1:0]     slot_handle,
  output logic [PRIORITY_WIDTH-1:0]   slot_prio
);

  localparam int CW = $clog2(DEPTH+1);

  logic occupied;
  logic at_tail;

  assign occupied = CW'(IDX) < count;
  assign at_tail  = CW'(IDX) == count;
  // Stored entry ranks below the incoming one: it moves back.
  assign lt       = occupied && (slot_prio < new_prio);

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (lt_prev) begin
        slot_handle <= prev_handle;
        slot_prio   <= prev_prio;
      end else if (lt || at_tail) begin
        slot_handle <= new_handle;
        slot_prio   <= new_prio;
      end
    end else if (ctl.deq) begin
      slot_handle <= next_handle;
      slot_prio   <= next_prio;
    end
  end

endmodule

/* design/stable_priority_queue.sv */
// ---------------------------------------------------------------------------
// stable_priority_queue
// Bounded priority queue kept sorted in a row of shifting slot cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one word per operation:
//   opcode 0 enqueues {item_handle, item_priority}, opcode 1 dequeues the
//   head. Higher priority is served first; equal priorities leave in
//   arrival order.
//   Output channel (out_valid/out_ready) returns one word per operation:
//   status (done, full, empty), the dequeued handle and priority (zero
//   otherwise) and the occupancy after the operation.
//   The result word is registered, valid the cycle after the input is taken.
//   Throughput: one operation per cycle while the output is not stalled.
//   All cells compare against the incoming priority in parallel and shift
//   in the same edge.
//   A stalled receiver holds the output register; in_ready drops until
//   that word is taken, so nothing is lost or repeated.
//   Reset (rst, synchronous) empties the queue and clears out_valid; slot
//   contents are left as they are and only slots below the count are read.
// ---------------------------------------------------------------------------
`include "stable_priority_queue_defines.svh"

module stable_priority_queue #(
  parameter int DEPTH          = spq_pkg::DEPTH_DEF,
  parameter int PRIORITY_WIDTH = spq_pkg::PRIORITY_WIDTH_DEF,
  parameter int HANDLE_WIDTH   = spq_pkg::HANDLE_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             opcode,
  input  logic [HANDLE_WIDTH-1:0]          item_handle,
  input  logic [PRIORITY_WIDTH-1:0]        item_priority,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [spq_pkg::STATUS_W-1:0]     status,
  output logic [HANDLE_WIDTH-1:0]          out_handle,
  output logic [PRIORITY_WIDTH-1:0]        out_priority,
  output logic [$clog2(DEPTH+1)-1:0]       occupancy
);

  localparam int CW = $clog2(DEPTH+1);

  // Entry count and per-cell chain signals.
  logic [CW-1:0]             count;
  logic [CW-1:0]             count_next;
  logic [HANDLE_WIDTH-1:0]   hnd [DEPTH];
  logic [PRIORITY_WIDTH-1:0] pri [DEPTH];
  logic                      lt  [DEPTH];

  logic                      accept;
  logic                      full;
  logic                      empty;
  spq_pkg::spq_ctl_t         ctl;
  spq_pkg::spq_status_t      status_next;

  // A word is taken whenever the output register is free or draining.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;
  assign full     = count == CW'(DEPTH);
  assign empty    = count == '0;

  assign ctl.enq = accept && (opcode == spq_pkg::OP_ENQ) && !full;
  assign ctl.deq = accept && (opcode == spq_pkg::OP_DEQ) && !empty;

  // Slot row: cell 0 is the head. Each cell sees its head-side neighbor's
  // "ranks below new" flag chain and both neighbors' contents.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                      lt_prev_i;
    logic [HANDLE_WIDTH-1:0]   prev_h, next_h;
    logic [PRIORITY_WIDTH-1:0] prev_p, next_p;

    if (i == 0) begin : g_head
      assign lt_prev_i = 1'b0;
      assign prev_h    = item_handle;
      assign prev_p    = item_priority;
    end else begin : g_mid
      assign lt_prev_i = lt[i-1];
      assign prev_h    = hnd[i-1];
      assign prev_p    = pri[i-1];
    end

    if (i == DEPTH-1) begin : g_tail
      assign next_h = hnd[i];
      assign next_p = pri[i];
    end else begin : g_body
      assign next_h = hnd[i+1];
      assign next_p = pri[i+1];
    end

    spq_cell #(
      .IDX            (i),
      .DEPTH          (DEPTH),
      .PRIORITY_WIDTH (PRIORITY_WIDTH),
      .HANDLE_WIDTH   (HANDLE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .count       (count),
      .new_handle  (item_handle),
      .new_prio    (item_priority),
      .lt_prev     (lt_prev_i),
      .prev_handle (prev_h),
      .prev_prio   (prev_p),
      .next_handle (next_h),
      .next_prio   (next_p),
      .lt          (lt[i]),
      .slot_handle (hnd[i]),
      .slot_prio   (pri[i])
    );
  end

  // Count and result status for the word being taken.
  always_comb begin
    count_next  = count;
    status_next = spq_pkg::ST_DONE;
    if (opcode == spq_pkg::OP_ENQ) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        count_next = count + CW'(1);
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        count_next = count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
      end
      if (accept) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Output payload; head cell is read before this edge's shift.
  always_ff @(posedge clk) begin
    if (accept) begin
      status    <= status_next;
      occupancy <= count_next;
      if (ctl.deq) begin
        out_handle   <= hnd[0];
        out_priority <= pri[0];
      end else begin
        out_handle   <= '0;
        out_priority <= '0;
      end
    end
  end

  `SPQ_ASSERT(a_count_bound, count <= CW'(DEPTH),
    "entry count above depth")
  `SPQ_ASSERT(a_full_reject,
    accept && opcode == spq_pkg::OP_ENQ && full |=>
      out_valid && status == spq_pkg::ST_FULL && count == CW'(DEPTH),
    "full enqueue not rejected")
  `SPQ_ASSERT(a_deq_count,
    ctl.deq |=> status == spq_pkg::ST_DONE && count == $past(count) - CW'(1),
    "dequeue count mismatch")
  `SPQ_ASSERT_ALWAYS(a_stall_block, out_valid && !out_ready |-> !in_ready,
    "input taken while result stalled")

endmodule
